// ===== rtl/tccn_pkg.sv =====
package tccn_pkg;

    localparam int WIN_DEPTH   = 7;
    localparam int FILL_W      = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0] MARK_BYTE  = 8'hFF;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    // Word index of the keep_punct register on the configuration port.
    localparam logic REG_KEEP_PUNCT = 1'b0;

    // The tag that is blanked out, in lower case.
    localparam logic [7:0] TAG_TEXT [WIN_DEPTH] = '{
        8'h3C, 8'h73, 8'h74, 8'h72, 8'h69, 8'h6E, 8'h67
    };

    // One window head with the lookahead facts that the back end needs.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
        logic       copy_pair;
        logic       paren_c;
        logic       plus_keep;
        logic       tag_hit;
    } q_item_t;

endpackage

// ===== rtl/tccn_front.sv =====
module tccn_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    output logic                 q_valid,
    input  logic                 q_ready,
    output tccn_pkg::q_item_t    q_item
);

    logic [7:0]                  win_reg  [tccn_pkg::WIN_DEPTH];
    logic [7:0]                  win_next [tccn_pkg::WIN_DEPTH];
    logic [tccn_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic                        flush_reg, flush_next;
    logic                        pop;
    logic                        accept;
    logic [tccn_pkg::FILL_W-1:0] ins_idx;
    logic                        tag_hit;
    logic [7:0]                  lc;
    logic [7:0]                  nx;

    // A full window retires its head when the queue has room; a flush drains it one per cycle while the queue has room.
    assign pop      = q_ready && ((fill_reg == 3'd7) || (flush_reg && (fill_reg != 3'd0)));
    assign s_tready = !flush_reg && ((fill_reg != 3'd7) || pop);
    assign accept   = s_tvalid && s_tready;
    assign ins_idx  = fill_reg - {2'b00, pop};
    assign q_valid  = pop;
    assign nx       = win_reg[1];

    always_comb begin
        tag_hit = (fill_reg == 3'd7);
        for (int i = 0; i < tccn_pkg::WIN_DEPTH; i++) begin
            lc = win_reg[i];
            if (lc >= 8'h41 && lc <= 8'h5A) begin
                lc = lc + 8'd32;
            end
            if (lc != tccn_pkg::TAG_TEXT[i]) begin
                tag_hit = 1'b0;
            end
        end
    end

    always_comb begin
        q_item.text_byte = win_reg[0];
        q_item.is_last   = flush_reg && (fill_reg == 3'd1);
        q_item.copy_pair = (win_reg[0] == 8'hC2) && (fill_reg >= 3'd2) && (nx == 8'hA9);
        q_item.paren_c   = (fill_reg >= 3'd3) && ((nx | 8'h20) == 8'h63) &&
                           (win_reg[2] == 8'h29);
        q_item.plus_keep = (fill_reg < 3'd2) || (nx inside {8'h00, 8'h20, 8'h09, 8'h0A, 8'h0D});
        q_item.tag_hit   = tag_hit;
    end

    always_comb begin
        for (int i = 0; i < tccn_pkg::WIN_DEPTH - 1; i++) begin
            win_next[i] = pop ? win_reg[i+1] : win_reg[i];
        end
        win_next[tccn_pkg::WIN_DEPTH-1] = win_reg[tccn_pkg::WIN_DEPTH-1];
        if (accept) begin
            win_next[ins_idx] = s_tdata;
        end
        fill_next  = fill_reg - {2'b00, pop} + {2'b00, accept};
        flush_next = flush_reg;
        if (accept && s_tlast) begin
            flush_next = 1'b1;
        end else if (pop && (fill_reg == 3'd1)) begin
            flush_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < tccn_pkg::WIN_DEPTH; i++) begin
            win_reg[i] <= win_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            flush_reg <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            flush_reg <= flush_next;
        end
    end

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 3'd7)
        else $error("window fill out of range");

    a_no_accept_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> !accept)
        else $error("byte accepted while the window flushes");

endmodule

// ===== rtl/tccn_fifo.sv =====
module tccn_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  tccn_pkg::q_item_t push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output tccn_pkg::q_item_t pop_item
);

    tccn_pkg::q_item_t           mem_reg [tccn_pkg::QUEUE_DEPTH];
    logic [tccn_pkg::QPTR_W-1:0] wr_reg, wr_next;
    logic [tccn_pkg::QPTR_W-1:0] rd_reg, rd_next;
    logic [tccn_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                        do_push, do_pop;

    assign push_ready = (cnt_reg != tccn_pkg::QCNT_W'(tccn_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + {{(tccn_pkg::QCNT_W-1){1'b0}}, do_push}
                           - {{(tccn_pkg::QCNT_W-1){1'b0}}, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/tccn_back.sv =====
module tccn_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              keep_punct,
    input  logic              q_valid,
    output logic              q_ready,
    input  tccn_pkg::q_item_t q_item,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic [1:0] pass_reg, pass_next;
    logic [2:0] blank_reg, blank_next;
    logic       load;
    logic [7:0] b;

    assign load     = q_valid && (!valid_reg || m_tready);
    assign q_ready  = load;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign b        = q_item.text_byte;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        pass_next  = pass_reg;
        blank_next = blank_reg;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            last_next  = q_item.is_last;
            data_next  = b;
            if (pass_reg != 2'd0) begin
                pass_next = pass_reg - 2'd1;
            end else if (blank_reg != 3'd0) begin
                // The rest of a blanked tag.
                data_next  = tccn_pkg::SPACE_BYTE;
                blank_next = blank_reg - 3'd1;
            end else if (q_item.copy_pair) begin
                pass_next = 2'd1;
            end else if (b[7]) begin
                data_next = tccn_pkg::MARK_BYTE;
            end else if (b == 8'h28) begin
                if (q_item.paren_c) begin
                    pass_next = 2'd2;
                end else begin
                    data_next = tccn_pkg::SPACE_BYTE;
                end
            end else if (b == 8'h3C) begin
                if (q_item.tag_hit) begin
                    data_next  = tccn_pkg::SPACE_BYTE;
                    blank_next = 3'd6;
                end
            end else if (b == 8'h2B) begin
                if (!q_item.plus_keep) begin
                    data_next = tccn_pkg::SPACE_BYTE;
                end
            end else if (b inside {8'h07, [8'h09:8'h0D], 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h2A,
                                   8'h3D, 8'h23, 8'h24, 8'h7C, 8'h25, 8'h21, 8'h3F, 8'h60,
                                   8'h22, 8'h27}) begin
                data_next = tccn_pkg::SPACE_BYTE;
            end else if (b inside {8'h29, 8'h2C, 8'h3A, 8'h3B}) begin
                if (!keep_punct) begin
                    data_next = tccn_pkg::SPACE_BYTE;
                end
            end else if (b == 8'h2E) begin
                if (!keep_punct) begin
                    data_next = tccn_pkg::MARK_BYTE;
                end
            end else if (b inside {[8'h00:8'h06], [8'h0E:8'h1F], 8'h7E}) begin
                data_next = tccn_pkg::MARK_BYTE;
            end
            // Every string starts fresh.
            if (q_item.is_last) begin
                pass_next  = 2'd0;
                blank_next = 3'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pass_reg  <= 2'd0;
            blank_reg <= 3'd0;
        end else begin
            valid_reg <= valid_next;
            pass_reg  <= pass_next;
            blank_reg <= blank_next;
        end
    end

    a_counts_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !((pass_reg != 2'd0) && (blank_reg != 3'd0)))
        else $error("passthrough and tag blanking active together");

    a_fresh_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && q_item.is_last) |=> ((pass_reg == 2'd0) && (blank_reg == 3'd0)))
        else $error("string state not cleared after last byte");

    a_pass_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pass_reg != 2'd3) && (blank_reg <= 3'd6))
        else $error("string state counter out of range");

endmodule

// ===== rtl/text_char_class_normalizer.sv =====
// Text character class normalizer.
// The s_ channel takes one text byte per transfer, with s_tlast on the final
// byte of a string; the m_ channel returns exactly one normalized byte per
// input byte, in order, with m_tlast on the final byte of the string.
// A byte is classified once six more bytes of its string have arrived, or
// when the string ends; after s_tlast the window of up to seven bytes
// drains one byte per cycle while the queue has room, and no new byte is
// taken until it is empty. Throughput is one byte per cycle inside a string
// while the queue has room, set by the seven-byte lookahead window that
// retires one head per cycle. A byte leaves the window for the queue once
// its lookahead is complete, then enters the output register when free.
// keep_punct is written on the APB port at paddr[2] = 0; the user must write it
// only while the block idles, which the block does not enforce. Reset (aresetn
// low, synchronous) empties the window, the queue and the output register and
// clears keep_punct. When the receiver stalls, the output register holds, the
// four-entry queue fills, then the window fills, and then s_tready drops.
module text_char_class_normalizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // out_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              keep_punct_reg, keep_punct_next;
    logic              f_valid, f_ready;
    tccn_pkg::q_item_t f_item;
    logic              b_valid, b_ready;
    tccn_pkg::q_item_t b_item;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == tccn_pkg::REG_KEEP_PUNCT) ? {31'b0, keep_punct_reg} : 32'b0;

    always_comb begin
        keep_punct_next = keep_punct_reg;
        if (psel && penable && pwrite && (paddr[2] == tccn_pkg::REG_KEEP_PUNCT)) begin
            keep_punct_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_punct_reg <= 1'b0;
        end else begin
            keep_punct_reg <= keep_punct_next;
        end
    end

    tccn_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_item   (f_item)
    );

    tccn_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_item   (b_item)
    );

    tccn_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .keep_punct (keep_punct_reg),
        .q_valid    (b_valid),
        .q_ready    (b_ready),
        .q_item     (b_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
